@@ rtl/fct_pkg.sv @@
// ----------------------------------------------------------------------------
// fct_pkg: shared widths, reset values and types of the facing cone test
// Holds the field widths, the intermediate widths of the exact squared-cosine
// test, the request queue geometry and the work item handed front to back.
// ----------------------------------------------------------------------------
package fct_pkg;

   // field widths
   localparam int HeadW   = 16;             // heading component, signed
   localparam int PosW    = 24;             // position coordinate, signed
   localparam int OffW    = PosW + 1;       // target - own, signed
   localparam int ThrW    = 8;              // cosine threshold, Q0.8
   localparam int SqThrW  = 2 * ThrW;       // threshold squared

   // intermediate widths (magnitudes bounded by the field ranges)
   localparam int ProdHdW = 41;             // heading * offset, signed
   localparam int HsqW    = 31;             // heading component squared
   localparam int DsqW    = 48;             // offset component squared
   localparam int DotW    = 43;             // dot product, signed
   localparam int HhW     = 32;             // |h|^2
   localparam int DdW     = 50;             // |d|^2
   localparam int MagW    = 41;             // positive dot magnitude
   localparam int MagLoW  = 24;
   localparam int MagHiW  = MagW - MagLoW;
   localparam int LhsW    = 2 * MagW;       // dot^2
   localparam int ScaleW  = 16;             // dot^2 is scaled by 2^16
   localparam int TthW    = SqThrW + HhW;   // t^2 * |h|^2
   localparam int TthLoW  = 24;
   localparam int TthHiW  = TthW - TthLoW;
   localparam int DdLoW   = 25;
   localparam int DdHiW   = DdW - DdLoW;
   localparam int RhsW    = LhsW + ScaleW;  // t^2 * |h|^2 * |d|^2

   // register reset: 0.75 in Q0.8, kept as its square
   localparam logic [ThrW-1:0]   ThrReset   = 8'd192;
   localparam logic [SqThrW-1:0] SqThrReset = SqThrW'(ThrReset * ThrReset);

   // request queue between front and back
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // work item: heading and offset of one request
   typedef struct packed {
      logic signed [HeadW-1:0] hx;
      logic signed [HeadW-1:0] hy;
      logic signed [HeadW-1:0] hz;
      logic signed [OffW-1:0]  dx;
      logic signed [OffW-1:0]  dy;
      logic signed [OffW-1:0]  dz;
   } fct_work_type;

endpackage

@@ rtl/fct_channels.sv @@
// ----------------------------------------------------------------------------
// fct_channels: request and response channels of the facing cone test
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface fct_req_if;
   import fct_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [HeadW-1:0] heading_x;
   logic signed [HeadW-1:0] heading_y;
   logic signed [HeadW-1:0] heading_z;
   logic signed [PosW-1:0]  own_x;
   logic signed [PosW-1:0]  own_y;
   logic signed [PosW-1:0]  own_z;
   logic signed [PosW-1:0]  target_x;
   logic signed [PosW-1:0]  target_y;
   logic signed [PosW-1:0]  target_z;

   modport source (
      output valid, heading_x, heading_y, heading_z,
             own_x, own_y, own_z, target_x, target_y, target_z,
      input  ready
   );

   modport sink (
      input  valid, heading_x, heading_y, heading_z,
             own_x, own_y, own_z, target_x, target_y, target_z,
      output ready
   );
endinterface

interface fct_rsp_if;
   logic valid;
   logic ready;
   logic facing;

   modport source (output valid, facing, input ready);
   modport sink   (input valid, facing, output ready);
endinterface

@@ rtl/fct_front.sv @@
// ----------------------------------------------------------------------------
// fct_front: request intake of the facing cone test
// Takes a request, forms the offset target - own and hands the work item to
// the queue; a holding register takes one more request while the queue is full.
// ----------------------------------------------------------------------------
module fct_front (
   input  logic                  clock,
   input  logic                  reset,
   fct_req_if.sink               req,
   input  logic                  q_space,
   output logic                  q_push,
   output fct_pkg::fct_work_type q_data
);
   import fct_pkg::*;

   logic         hold_valid_ff, hold_valid_in;
   fct_work_type work_ff, work_in;
   logic         take;

   // accept while the holding register is empty or drains this cycle
   assign q_push    = hold_valid_ff && q_space;
   assign req.ready = !hold_valid_ff || q_space;
   assign take      = req.valid && req.ready;
   assign q_data    = work_ff;

   // form the offset, one extra bit keeps it exact
   always_comb begin
      work_in.hx = req.heading_x;
      work_in.hy = req.heading_y;
      work_in.hz = req.heading_z;
      work_in.dx = OffW'(req.target_x) - OffW'(req.own_x);
      work_in.dy = OffW'(req.target_y) - OffW'(req.own_y);
      work_in.dz = OffW'(req.target_z) - OffW'(req.own_z);
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         work_ff <= work_in;
      end
   end

endmodule

@@ rtl/fct_queue.sv @@
// ----------------------------------------------------------------------------
// fct_queue: short work queue between front and back
// Circular buffer of QDepth work items with a fill count.
// ----------------------------------------------------------------------------
module fct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fct_pkg::fct_work_type push_data,
   output logic                  space,
   input  logic                  pop,
   output logic                  valid,
   output fct_pkg::fct_work_type head
);
   import fct_pkg::*;

   fct_work_type     entry_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign space   = count_ff != QCntW'(QDepth);
   assign valid   = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && space;
   assign do_pop  = pop && valid;

   // advance pointers with wrap, track the fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("queue fill beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue fill not reduced by a pop");

   a_push_gap: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> wr_ptr_ff != rd_ptr_ff || count_ff == QCntW'(QDepth))
      else $error("queue pointers meet while not full");

endmodule

@@ rtl/fct_back.sv @@
// ----------------------------------------------------------------------------
// fct_back: arithmetic pipeline of the facing cone test
// Five stages form dot, |h|^2 and |d|^2, then dot^2 and t^2*|h|^2*|d|^2 from
// partial products of at most 25 by 25 bits, and an output register holds
// the compare. All stages move together whenever the output can advance.
// ----------------------------------------------------------------------------
module fct_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  fct_pkg::fct_work_type     q_data,
   output logic                      q_pop,
   input  logic [fct_pkg::SqThrW-1:0] sq_thr,
   fct_rsp_if.source                 rsp
);
   import fct_pkg::*;

   localparam int DsqProdW = DsqW + 1;
   localparam int A0A0W    = 2 * MagLoW;
   localparam int A1A0W    = MagHiW + MagLoW;
   localparam int A1A1W    = 2 * MagHiW;
   localparam int XyW      = ((TthLoW > TthHiW) ? TthLoW : TthHiW)
                             + ((DdLoW > DdHiW) ? DdLoW : DdHiW);
   localparam int NumStages = 5;

   logic                   advance;
   logic [NumStages-1:0]   sv_ff, sv_in;
   logic                   out_valid_ff;
   logic                   facing_ff, facing_in;

   // stage 1: products and squares
   logic signed [ProdHdW-1:0] p1_x_ff, p1_y_ff, p1_z_ff, p1_x_in, p1_y_in, p1_z_in;
   logic [HsqW-1:0] h1_x_ff, h1_y_ff, h1_z_ff, h1_x_in, h1_y_in, h1_z_in;
   logic [DsqW-1:0] d1_x_ff, d1_y_ff, d1_z_ff, d1_x_in, d1_y_in, d1_z_in;
   // stage 2: sums
   logic signed [DotW-1:0] dot2_ff, dot2_in;
   logic [HhW-1:0]         hh2_ff, hh2_in;
   logic [DdW-1:0]         dd2_ff, dd2_in;
   // stage 3: dot partials and t^2*|h|^2
   logic [MagW-1:0]   mag3;
   logic              pos3_ff, pos3_in;
   logic [A0A0W-1:0]  a0a0_ff, a0a0_in;
   logic [A1A0W-1:0]  a1a0_ff, a1a0_in;
   logic [A1A1W-1:0]  a1a1_ff, a1a1_in;
   logic [TthW-1:0]   tth3_ff, tth3_in;
   logic [DdW-1:0]    dd3_ff;
   // stage 4: dot^2 and right-side partials
   logic              pos4_ff;
   logic [LhsW-1:0]   lhs4_ff, lhs4_in;
   logic [XyW-1:0]    x0y0_ff, x0y1_ff, x1y0_ff, x1y1_ff;
   logic [XyW-1:0]    x0y0_in, x0y1_in, x1y0_in, x1y1_in;
   // stage 5: right side
   logic              pos5_ff;
   logic [LhsW-1:0]   lhs5_ff;
   logic [RhsW-1:0]   rhs5_ff, rhs5_in;

   // move every stage when the output register is free or being taken
   assign advance    = !out_valid_ff || rsp.ready;
   assign q_pop      = advance && q_valid;
   assign rsp.valid  = out_valid_ff;
   assign rsp.facing = facing_ff;
   assign sv_in      = {sv_ff[NumStages-2:0], q_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         sv_ff        <= sv_in;
         out_valid_ff <= sv_ff[NumStages-1];
      end
   end

   // stage 1: heading*offset lanes and squares
   always_comb begin
      p1_x_in = ProdHdW'($signed(q_data.hx)) * ProdHdW'($signed(q_data.dx));
      p1_y_in = ProdHdW'($signed(q_data.hy)) * ProdHdW'($signed(q_data.dy));
      p1_z_in = ProdHdW'($signed(q_data.hz)) * ProdHdW'($signed(q_data.dz));
      h1_x_in = HsqW'(HhW'($signed(q_data.hx)) * HhW'($signed(q_data.hx)));
      h1_y_in = HsqW'(HhW'($signed(q_data.hy)) * HhW'($signed(q_data.hy)));
      h1_z_in = HsqW'(HhW'($signed(q_data.hz)) * HhW'($signed(q_data.hz)));
      d1_x_in = DsqW'(DsqProdW'($signed(q_data.dx)) * DsqProdW'($signed(q_data.dx)));
      d1_y_in = DsqW'(DsqProdW'($signed(q_data.dy)) * DsqProdW'($signed(q_data.dy)));
      d1_z_in = DsqW'(DsqProdW'($signed(q_data.dz)) * DsqProdW'($signed(q_data.dz)));
   end

   // stage 2: three-way sums
   always_comb begin
      dot2_in = DotW'(p1_x_ff) + DotW'(p1_y_ff) + DotW'(p1_z_ff);
      hh2_in  = HhW'(h1_x_ff) + HhW'(h1_y_ff) + HhW'(h1_z_ff);
      dd2_in  = DdW'(d1_x_ff) + DdW'(d1_y_ff) + DdW'(d1_z_ff);
   end

   // stage 3: split the dot magnitude, scale |h|^2 by t^2
   always_comb begin
      pos3_in = !dot2_ff[DotW-1] && (dot2_ff != '0);
      mag3    = dot2_ff[MagW-1:0];
      a0a0_in = A0A0W'(mag3[MagLoW-1:0]) * A0A0W'(mag3[MagLoW-1:0]);
      a1a0_in = A1A0W'(mag3[MagW-1:MagLoW]) * A1A0W'(mag3[MagLoW-1:0]);
      a1a1_in = A1A1W'(mag3[MagW-1:MagLoW]) * A1A1W'(mag3[MagW-1:MagLoW]);
      tth3_in = TthW'(sq_thr) * TthW'(hh2_ff);
   end

   // stage 4: assemble dot^2, cross partials of t^2*|h|^2 by |d|^2
   always_comb begin
      lhs4_in = (LhsW'(a1a1_ff) << (2 * MagLoW))
              + (LhsW'(a1a0_ff) << (MagLoW + 1))
              + LhsW'(a0a0_ff);
      x0y0_in = XyW'(tth3_ff[TthLoW-1:0]) * XyW'(dd3_ff[DdLoW-1:0]);
      x0y1_in = XyW'(tth3_ff[TthLoW-1:0]) * XyW'(dd3_ff[DdW-1:DdLoW]);
      x1y0_in = XyW'(tth3_ff[TthW-1:TthLoW]) * XyW'(dd3_ff[DdLoW-1:0]);
      x1y1_in = XyW'(tth3_ff[TthW-1:TthLoW]) * XyW'(dd3_ff[DdW-1:DdLoW]);
   end

   // stage 5: assemble the right side
   always_comb begin
      rhs5_in = (RhsW'(x1y1_ff) << (TthLoW + DdLoW))
              + (RhsW'(x1y0_ff) << TthLoW)
              + (RhsW'(x0y1_ff) << DdLoW)
              + RhsW'(x0y0_ff);
   end

   // output: strict compare of 2^16*dot^2 against the right side
   assign facing_in = pos5_ff && ({lhs5_ff, ScaleW'(0)} > rhs5_ff);

   // hold all payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_x_ff   <= p1_x_in;
         p1_y_ff   <= p1_y_in;
         p1_z_ff   <= p1_z_in;
         h1_x_ff   <= h1_x_in;
         h1_y_ff   <= h1_y_in;
         h1_z_ff   <= h1_z_in;
         d1_x_ff   <= d1_x_in;
         d1_y_ff   <= d1_y_in;
         d1_z_ff   <= d1_z_in;
         dot2_ff   <= dot2_in;
         hh2_ff    <= hh2_in;
         dd2_ff    <= dd2_in;
         pos3_ff   <= pos3_in;
         a0a0_ff   <= a0a0_in;
         a1a0_ff   <= a1a0_in;
         a1a1_ff   <= a1a1_in;
         tth3_ff   <= tth3_in;
         dd3_ff    <= dd2_ff;
         pos4_ff   <= pos3_ff;
         lhs4_ff   <= lhs4_in;
         x0y0_ff   <= x0y0_in;
         x0y1_ff   <= x0y1_in;
         x1y0_ff   <= x1y0_in;
         x1y1_ff   <= x1y1_in;
         pos5_ff   <= pos4_ff;
         lhs5_ff   <= lhs4_ff;
         rhs5_ff   <= rhs5_in;
         facing_ff <= facing_in;
      end
   end

   a_last_stage_out: assert property (@(posedge clock) disable iff (reset)
      advance && sv_ff[NumStages-1] |=> out_valid_ff)
      else $error("pipeline item lost before the output register");

   a_not_positive: assert property (@(posedge clock) disable iff (reset)
      advance && sv_ff[NumStages-1] && !pos5_ff |=> !facing_ff)
      else $error("facing reported for a non-positive dot product");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> sv_ff == $past(sv_ff))
      else $error("pipeline moved while the output was stalled");

endmodule

@@ rtl/facing_cone_test.sv @@
// ----------------------------------------------------------------------------
// facing_cone_test: view-cone test of a target against a heading
// Each request carries a heading h, an own position and a target position;
// the response tells whether the angle cosine between h and target - own is
// strictly above the threshold set in csr_wr_data (Q0.8).
//
// Channels: req_ch takes requests, rsp_ch returns one facing bit per request
// in request order; both transfer on a clock edge with valid and ready high.
// csr_wr_en writes the threshold; write it only while no request is in
// flight.
// Path: a request passes the intake register, the queue, five arithmetic
// stages and the output register before its response is valid.
// Throughput: one request per cycle while rsp_ch is ready, set by the fully
// pipelined multiplier stages of the back end.
// Reset: empties the queue and pipeline and sets the threshold to 0.75.
// Stall: while rsp_ch is not ready the back end holds, the four-entry queue
// and the intake register absorb requests, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module facing_cone_test (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [fct_pkg::ThrW-1:0]  csr_wr_data,
   fct_req_if.sink                   req_ch,
   fct_rsp_if.source                 rsp_ch
);
   import fct_pkg::*;

   logic [SqThrW-1:0] sq_thr_ff, sq_thr_in;
   logic              q_push, q_space, q_pop, q_valid;
   fct_work_type      q_in_data, q_head;

   // keep the threshold as its square, that is all the test needs
   assign sq_thr_in = SqThrW'(csr_wr_data) * SqThrW'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_thr_ff <= SqThrReset;
      end else if (csr_wr_en) begin
         sq_thr_ff <= sq_thr_in;
      end
   end

   fct_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_space (q_space),
      .q_push  (q_push),
      .q_data  (q_in_data)
   );

   fct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .space     (q_space),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   fct_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_head),
      .q_pop   (q_pop),
      .sq_thr  (sq_thr_ff),
      .rsp     (rsp_ch)
   );

endmodule
